FILE: src/ctcgd_pkg.sv
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Shared constants, types and helpers for the CTC greedy decoder.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

    localparam int MAX_CLASSES = 128;
    localparam int CLS_W       = $clog2(MAX_CLASSES);
    localparam int SCORE_W     = 16;
    localparam int CFG_W       = 8;
    localparam int CHAR_W      = 8;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [8:0] CHAR_LETTERS = 9'd26;
    localparam logic [8:0] CHAR_ALNUM   = 9'd36;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    // One closed time step handed from front to back.
    typedef struct packed {
        logic [CLS_W-1:0] winner;
        logic             last;
    } step_rec_t;

    // Blank index for a programmed class count, saturated to 2..MAX_CLASSES.
    function automatic logic [CLS_W-1:0] eff_blank(input logic [CFG_W-1:0] n);
        logic [8:0] e;
        e = 9'(n);
        if (e < 9'd2)
            e = 9'd2;
        if (e > 9'(MAX_CLASSES))
            e = 9'(MAX_CLASSES);
        return CLS_W'(e - 9'd1);
    endfunction

    function automatic logic [CHAR_W-1:0] class_char(input logic [CLS_W-1:0] c);
        logic [8:0] cw;
        cw = 9'(c);
        if (cw < CHAR_LETTERS)
            return CHAR_LOWER_A + CHAR_W'(cw);
        else if (cw < CHAR_ALNUM)
            return CHAR_DIGIT_0 + CHAR_W'(cw - CHAR_LETTERS);
        else
            return CHAR_SPACE;
    endfunction

endpackage

FILE: src/ctcgd_front.sv
// ----------------------------------------------------------------------------
// ctcgd_front
// Accepts scores, runs the per-step argmax and emits one record per step.
// ----------------------------------------------------------------------------
module ctcgd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              restart,
    input  logic [ctcgd_pkg::CLS_W-1:0]       blank,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [ctcgd_pkg::SCORE_W-1:0] score,
    input  logic                              seq_end,
    input  logic                              q_full,
    output logic                              push,
    output ctcgd_pkg::step_rec_t              push_rec
);

    logic [ctcgd_pkg::CLS_W-1:0]          cnt_reg, cnt_next;
    logic signed [ctcgd_pkg::SCORE_W-1:0] best_reg, best_next;
    logic [ctcgd_pkg::CLS_W-1:0]          bcls_reg, bcls_next;
    logic                                 accept;
    logic                                 close;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign close    = (cnt_reg == blank) || seq_end;

    always_comb
    begin
        best_next = best_reg;
        bcls_next = bcls_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            if (cnt_reg == '0)
            begin
                best_next = score;
                bcls_next = '0;
            end
            else if (score > best_reg)
            begin
                best_next = score;
                bcls_next = cnt_reg;
            end
            cnt_next = close ? '0 : cnt_reg + 1'b1;
        end
        if (restart)
            cnt_next = '0;
    end

    assign push            = accept && close;
    assign push_rec.winner = bcls_next;
    assign push_rec.last   = seq_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            best_reg <= '0;
            bcls_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            best_reg <= best_next;
            bcls_reg <= bcls_next;
        end
    end

    // counter never runs past the blank index
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= blank)
        else $error("class counter beyond blank index");

    // a record is only pushed with room in the queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full queue");

endmodule

FILE: src/ctcgd_fifo.sv
// ----------------------------------------------------------------------------
// ctcgd_fifo
// Short flop queue of step records between front and back.
// ----------------------------------------------------------------------------
module ctcgd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ctcgd_pkg::step_rec_t push_rec,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output ctcgd_pkg::step_rec_t pop_rec
);

    localparam int PTR_W = (ctcgd_pkg::FIFO_DEPTH > 1) ? $clog2(ctcgd_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(ctcgd_pkg::FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ctcgd_pkg::FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ctcgd_pkg::FIFO_DEPTH);

    ctcgd_pkg::step_rec_t mem_reg [ctcgd_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_rec   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        if (do_pop)
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: src/ctcgd_back.sv
// ----------------------------------------------------------------------------
// ctcgd_back
// Takes step records, applies blank/repeat collapse, maps to ASCII and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module ctcgd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic [ctcgd_pkg::CLS_W-1:0]   restart_blank,
    input  logic [ctcgd_pkg::CLS_W-1:0]   blank,
    input  logic                          q_valid,
    input  ctcgd_pkg::step_rec_t          q_rec,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ctcgd_pkg::CHAR_W-1:0]  char_code,
    output logic                          has_char,
    output logic                          text_end
);

    logic [ctcgd_pkg::CLS_W-1:0]  prev_reg, prev_next;
    logic                         vld_reg, vld_next;
    logic [ctcgd_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                         has_reg, has_next;
    logic                         end_reg, end_next;
    logic                         has_now;

    assign pop     = q_valid && (!vld_reg || out_ready);
    assign has_now = (q_rec.winner != blank) && (q_rec.winner != prev_reg);

    always_comb
    begin
        prev_next = prev_reg;
        vld_next  = vld_reg;
        char_next = char_reg;
        has_next  = has_reg;
        end_next  = end_reg;
        if (out_ready)
            vld_next = 1'b0;
        if (pop)
        begin
            vld_next  = 1'b1;
            has_next  = has_now;
            char_next = has_now ? ctcgd_pkg::class_char(q_rec.winner) : '0;
            end_next  = q_rec.last;
            prev_next = q_rec.last ? blank : q_rec.winner;
        end
        if (restart)
            prev_next = restart_blank;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= ctcgd_pkg::eff_blank(8'd100);
            vld_reg  <= 1'b0;
        end
        else
        begin
            prev_reg <= prev_next;
            vld_reg  <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        has_reg  <= has_next;
        end_reg  <= end_next;
    end

    assign out_valid = vld_reg;
    assign char_code = char_reg;
    assign has_char  = has_reg;
    assign text_end  = end_reg;

    // a character result always carries a printable code, a silent one zero
    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> (has_reg ? (char_reg != '0) : (char_reg == '0)))
        else $error("char_code does not match has_char");

    // closing a text puts the previous winner back to blank
    a_prev_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_rec.last && !restart) |=> (prev_reg == $past(blank)))
        else $error("previous winner not blank after text end");

    // a stalled result is not overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !out_ready) |-> !pop)
        else $error("pop while result stalled");

endmodule

FILE: src/ctc_greedy_decoder_unit.sv
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_unit
// CTC greedy decoder: per-step argmax over class scores, blank and repeat
// collapse, class to ASCII mapping.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                 tuser      tlast
//  s_axis    in   [15:0] score (Q8.8)   -          seq_end
//  m_axis    out  [7:0]  char_code      has_char   text_end
//  cfg       in   [7:0]  class_count    -          -   (written when cfg_we)
//
//  One score accepted per cycle while the two-entry record queue has room;
//  a step result enters that queue when its closing score is taken, then
//  the output register (argmax in the front, collapse and mapping in the back).
//  Reset: class_count 100, previous winner blank, no result pending.
//  s_axis_tready drops only when the record queue is full, which happens
//  when m_axis stalls with results backed up.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] score
    input  logic        s_axis_tlast,   // seq_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tuser,   // [0] has_char
    output logic        m_axis_tlast,   // text_end
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata       // [7:0] class_count
);

    logic [ctcgd_pkg::CFG_W-1:0] ncls_reg;
    logic [ctcgd_pkg::CLS_W-1:0] blank;
    logic [ctcgd_pkg::CLS_W-1:0] new_blank;
    logic                        q_full, q_valid, push, pop;
    ctcgd_pkg::step_rec_t        push_rec, pop_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ncls_reg <= 8'd100;
        else if (cfg_we)
            ncls_reg <= cfg_wdata;
    end

    assign blank     = ctcgd_pkg::eff_blank(ncls_reg);
    assign new_blank = ctcgd_pkg::eff_blank(cfg_wdata);

    ctcgd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_we),
        .blank    (blank),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .score    (s_axis_tdata),
        .seq_end  (s_axis_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    ctcgd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_rec   (pop_rec)
    );

    ctcgd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (cfg_we),
        .restart_blank (new_blank),
        .blank         (blank),
        .q_valid       (q_valid),
        .q_rec         (pop_rec),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .char_code     (m_axis_tdata),
        .has_char      (m_axis_tuser),
        .text_end      (m_axis_tlast)
    );

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ctc_greedy_decoder_unit. Streams class scores with
// random gaps on both sides, tracks argmax, blank/repeat collapse and the
// class-to-ASCII mapping in a local decoder model, and compares every step
// result against it. Covers the reset class count, ties, repeats, blanks,
// early and regular text end, class-count saturation and output backpressure.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ctcgd_pkg::CHAR_W-1:0] char_code;
        logic                         has_char;
        logic                         text_end;
    } step_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] score
    logic        s_axis_tlast;   // seq_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] char_code
    logic        m_axis_tuser;   // [0] has_char
    logic        m_axis_tlast;   // text_end
    logic        cfg_we;
    logic [7:0]  cfg_wdata;      // [7:0] class_count

    // decoder model state
    logic [ctcgd_pkg::CFG_W-1:0]          dec_classes_reg;
    logic [ctcgd_pkg::CLS_W-1:0]          dec_class_idx;
    logic signed [ctcgd_pkg::SCORE_W-1:0] dec_best_score;
    logic [ctcgd_pkg::CLS_W-1:0]          dec_best_class;
    logic [ctcgd_pkg::CLS_W-1:0]          dec_prev_winner;

    step_out_t pending_steps[$];

    int errors;
    int idle_on;
    int rx_hold_left;
    int scores_in;
    int steps_out;
    int chars_out;
    int text_ends;
    int class_writes;

    ctc_greedy_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Class count actually used by the block, saturated to 2..MAX_CLASSES.
    function automatic int sat_classes(input logic [ctcgd_pkg::CFG_W-1:0] raw);
        int n;
        n = int'(raw);
        if (n < 2)
            n = 2;
        if (n > ctcgd_pkg::MAX_CLASSES)
            n = ctcgd_pkg::MAX_CLASSES;
        return n;
    endfunction

    function automatic logic [ctcgd_pkg::CHAR_W-1:0] class_to_ascii(
        input logic [ctcgd_pkg::CLS_W-1:0] c);
        if (c < ctcgd_pkg::CLS_W'(26))
            return ctcgd_pkg::CHAR_LOWER_A + ctcgd_pkg::CHAR_W'(c);
        else if (c < ctcgd_pkg::CLS_W'(36))
            return ctcgd_pkg::CHAR_DIGIT_0
                   + ctcgd_pkg::CHAR_W'(c - ctcgd_pkg::CLS_W'(26));
        else
            return ctcgd_pkg::CHAR_SPACE;
    endfunction

    function automatic logic [15:0] rand_score();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return 16'($urandom);
        else if (r < 7)
            return 16'($urandom_range(0, 3));
        else if (r == 7)
            return 16'h7FFF;
        else if (r == 8)
            return 16'h8000;
        else
            return 16'(-$urandom_range(0, 3));
    endfunction

    task automatic restart_decoder(input logic [ctcgd_pkg::CFG_W-1:0] raw);
        dec_classes_reg = raw;
        dec_class_idx   = '0;
        dec_prev_winner = ctcgd_pkg::CLS_W'(sat_classes(raw) - 1);
    endtask

    // Running argmax per step; at step close, collapse blanks and repeats.
    task automatic decode_score(input logic [15:0] raw, input logic seq_end);
        logic signed [ctcgd_pkg::SCORE_W-1:0] sc;
        logic [ctcgd_pkg::CLS_W-1:0] blank;
        logic [ctcgd_pkg::CLS_W-1:0] winner;
        step_out_t                   res;
        int                          n;
        sc    = raw;
        n     = sat_classes(dec_classes_reg);
        blank = ctcgd_pkg::CLS_W'(n - 1);
        if (int'(dec_class_idx) >= n)
            dec_class_idx = '0;
        if (dec_class_idx == '0)
        begin
            dec_best_score = sc;
            dec_best_class = '0;
        end
        else if (sc > dec_best_score)
        begin
            dec_best_score = sc;
            dec_best_class = dec_class_idx;
        end
        if (dec_class_idx != blank && !seq_end)
        begin
            dec_class_idx = dec_class_idx + 1'b1;
            return;
        end
        winner       = dec_best_class;
        res.has_char = (winner != blank) && (winner != dec_prev_winner);
        res.char_code = res.has_char ? class_to_ascii(winner) : '0;
        res.text_end = seq_end;
        dec_prev_winner = seq_end ? blank : winner;
        dec_class_idx   = '0;
        pending_steps.push_back(res);
    endtask

    task automatic check_step(input step_out_t got);
        step_out_t want;
        steps_out++;
        if (got.has_char)
            chars_out++;
        if (got.text_end)
            text_ends++;
        if (pending_steps.size() == 0)
        begin
            $error("unexpected step result: char_code %0h has_char %0b text_end %0b",
                   got.char_code, got.has_char, got.text_end);
            errors++;
            return;
        end
        want = pending_steps.pop_front();
        if (got.char_code !== want.char_code)
        begin
            $error("char_code: expected %0h, got %0h", want.char_code, got.char_code);
            errors++;
        end
        if (got.has_char !== want.has_char)
        begin
            $error("has_char: expected %0b, got %0b", want.has_char, got.has_char);
            errors++;
        end
        if (got.text_end !== want.text_end)
        begin
            $error("text_end: expected %0b, got %0b", want.text_end, got.text_end);
            errors++;
        end
    endtask

    // One process for config, requests and results keeps model updates ordered.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            restart_decoder(8'd100);
            dec_best_score = '0;
            dec_best_class = '0;
        end
        else
        begin
            if (cfg_we)
                restart_decoder(cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
            begin
                scores_in++;
                decode_score(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready)
                check_step({m_axis_tdata, m_axis_tuser, m_axis_tlast});
        end
    end

    // Result side: random stalls, plus a long hold when a test asks for one.
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left--;
        end
        else
            m_axis_tready <= !(idle_on != 0 && $urandom_range(99) < 36);
    end

    task automatic send_score(input logic [15:0] sc, input logic seq_end);
        int gap;
        gap = (idle_on != 0 && $urandom_range(99) < 36) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sc;
        s_axis_tlast  <= seq_end;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        // a partial step may still sit in the front
        repeat (4) @(posedge clk);
    endtask

    task automatic write_classes(input logic [ctcgd_pkg::CFG_W-1:0] raw);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= raw;
        @(negedge clk);
        cfg_we    <= 1'b0;
        class_writes++;
    endtask

    // Sends one full step whose only top score sits at the given class.
    task automatic send_peak_step(input int n, input int peak, input logic seq_end);
        for (int c = 0; c < n; c++)
            send_score(c == peak ? 16'h0100 : 16'hFF00, seq_end && c == n - 1);
    endtask

    task automatic test_reset_classes();
        // blank sits at class 99 after reset
        send_peak_step(100, 99, 1'b0);
        send_score(16'hFF00, 1'b0);
        send_score(16'h0100, 1'b0);
        send_score(16'hFF00, 1'b1);
    endtask

    task automatic test_ties_and_repeats();
        write_classes(8'd4);
        send_score(16'h8000, 1'b0);
        send_score(16'h7FFF, 1'b0);
        send_score(16'h7FFF, 1'b0);
        send_score(16'h0000, 1'b0);
        // same winner again: collapsed
        send_score(16'h0000, 1'b0);
        send_score(16'h0005, 1'b0);
        send_score(16'h0005, 1'b0);
        send_score(16'h0005, 1'b0);
        // blank wins
        send_score(16'h0000, 1'b0);
        send_score(16'h0000, 1'b0);
        send_score(16'h0000, 1'b0);
        send_score(16'h0001, 1'b0);
        // repeat after blank gives a char again
        send_score(16'h0000, 1'b0);
        send_score(16'h0005, 1'b0);
        send_score(16'h0000, 1'b0);
        send_score(16'hFFFF, 1'b0);
    endtask

    task automatic test_early_end();
        send_score(16'h0001, 1'b0);
        send_score(16'h0000, 1'b1);
        send_score(16'h0003, 1'b1);
        send_score(16'h0000, 1'b0);
        send_score(16'h0000, 1'b0);
        send_score(16'h0000, 1'b0);
        send_score(16'h0009, 1'b1);
    endtask

    task automatic test_char_map();
        write_classes(8'd40);
        send_peak_step(40, 25, 1'b0);
        send_peak_step(40, 26, 1'b0);
        send_peak_step(40, 36, 1'b1);
    endtask

    task automatic test_saturation();
        write_classes(8'd0);
        send_score(16'h8000, 1'b0);
        send_score(16'h8000, 1'b0);
        send_score(16'h0000, 1'b0);
        send_score(16'h7FFF, 1'b0);
        write_classes(8'd1);
        send_score(16'h0005, 1'b0);
        send_score(16'h0000, 1'b1);
        write_classes(8'd255);
        send_peak_step(128, 126, 1'b0);
        for (int c = 0; c < 4; c++)
            send_score(c == 2 ? 16'h0100 : 16'hFF00, c == 3);
    endtask

    task automatic test_backpressure();
        write_classes(8'd2);
        @(posedge clk);
        rx_hold_left = 120;
        idle_on = 0;
        for (int i = 0; i < 40; i++)
            send_score(rand_score(), $urandom_range(9) == 0);
        idle_on = 1;
        wait_drained();
    endtask

    task automatic test_random(input int target);
        int sent;
        int phase;
        int budget;
        int n;
        int r;
        logic [ctcgd_pkg::CFG_W-1:0] raw;
        logic seq_end;
        sent  = 0;
        phase = 0;
        while (sent < target)
        begin
            r = $urandom_range(9);
            if (r < 6)
                raw = ctcgd_pkg::CFG_W'($urandom_range(2, 8));
            else if (r == 6)
                raw = ctcgd_pkg::CFG_W'($urandom_range(9, 40));
            else if (r == 7)
                raw = ctcgd_pkg::CFG_W'($urandom_range(0, 1));
            else if (r == 8)
                raw = ctcgd_pkg::CFG_W'($urandom_range(41, 80));
            else
                raw = ($urandom_range(1) != 0) ? 8'd128
                                               : ctcgd_pkg::CFG_W'($urandom_range(129, 255));
            write_classes(raw);
            idle_on = (phase == 2) ? 0 : 1;
            n = sat_classes(raw);
            budget = $urandom_range(20, 60);
            for (int done = 0; done < budget;)
            begin
                for (int c = 0; c < n; c++)
                begin
                    seq_end = (c == n - 1) ? ($urandom_range(99) < 15)
                                           : ($urandom_range(99) < 3);
                    send_score(rand_score(), seq_end);
                    done++;
                    sent++;
                    if (seq_end)
                        break;
                end
            end
            phase++;
        end
        idle_on = 1;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        errors        = 0;
        idle_on       = 1;
        rx_hold_left  = 0;
        scores_in     = 0;
        steps_out     = 0;
        chars_out     = 0;
        text_ends     = 0;
        class_writes  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_classes();
        test_ties_and_repeats();
        test_early_end();
        test_char_map();
        test_saturation();
        test_backpressure();
        test_random(80);

        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_steps.size() != 0)
        begin
            $error("%0d step results never arrived", pending_steps.size());
            errors++;
        end
        $display("tb: %0d scores in, %0d step results (%0d chars, %0d text ends)",
                 scores_in, steps_out, chars_out, text_ends);
        $display("tb: %0d class-count writes incl. saturated and max values, %0d errors",
                 class_writes, errors);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
